FILE: hw/rtl/lkv_pkg.sv
// lkv_pkg: shared sizes, codes and types of the LRU key-value cache.
// Used by lkv_rank_table, lru_key_value_cache and lkv_checker; depends on nothing.

package lkv_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W = IDX_W;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CAP_W  = 5;
    localparam int WORD_W = KEY_BITS + VALUE_BITS;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } lkv_state_t;

    // Recency update request from the sequencer to the rank table.
    typedef struct packed {
        logic             en;   // apply an update this cycle
        logic             hit;  // touch entry idx; else insert a put miss
        logic [IDX_W-1:0] idx;  // entry that hit
    } lkv_upd_t;

    // Capacity register saturated into 1 .. ENTRIES.
    function automatic logic [CAP_W-1:0] eff_cap(input logic [CAP_W-1:0] c);
        logic [CAP_W-1:0] r;
        r = c;
        if (c == '0)
        begin
            r = CAP_W'(1);
        end
        else if (int'(c) > ENTRIES)
        begin
            r = CAP_W'(ENTRIES);
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/lkv_kv_ram.sv
// lkv_kv_ram: single-port-write, single-port-read synchronous RAM with
// registered read data. Generic; no package dependency.

module lkv_kv_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64
) (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic                                        rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hw/rtl/lkv_rank_table.sv
// lkv_rank_table: valid bits, age ranks, occupancy and the capacity register.
// Picks the slot for a put miss and applies recency updates. Uses lkv_pkg.

module lkv_rank_table
    import lkv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [CAP_W-1:0]   cfg_wdata,
    input  lkv_upd_t           upd,
    output logic [ENTRIES-1:0] valid,
    output logic [IDX_W-1:0]   put_slot
);

    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [RANK_W-1:0]  rank_reg [ENTRIES];
    logic [RANK_W-1:0]  rank_next [ENTRIES];
    logic [CNT_W-1:0]   occ_reg, occ_next;
    logic [CAP_W-1:0]   cap_reg, cap_next;

    logic [CAP_W-1:0]   cap_eff;
    logic [CAP_W-1:0]   cap_new;
    logic               has_free;
    logic [IDX_W-1:0]   free_idx;
    logic               victim_found;
    logic [IDX_W-1:0]   victim_idx;
    logic [RANK_W-1:0]  oldest;
    logic               use_insert;
    logic               plain_fill;
    logic [IDX_W-1:0]   touch_idx;
    logic [RANK_W-1:0]  touch_old;
    logic               age_all;

    assign cap_eff = eff_cap(cap_reg);
    assign cap_new = eff_cap(cfg_wdata);
    assign oldest  = (occ_reg != '0) ? RANK_W'(occ_reg - CNT_W'(1)) : '0;

    // lowest free entry and lowest valid entry holding the oldest rank
    always_comb
    begin
        has_free     = 1'b0;
        free_idx     = '0;
        victim_found = 1'b0;
        victim_idx   = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                has_free = 1'b1;
                free_idx = IDX_W'(i);
            end
            if (valid_reg[i] && rank_reg[i] == oldest)
            begin
                victim_found = 1'b1;
                victim_idx   = IDX_W'(i);
            end
        end
    end

    assign use_insert = (int'(occ_reg) < int'(cap_eff)) && has_free;
    assign put_slot   = use_insert ? free_idx : (victim_found ? victim_idx : '0);
    assign plain_fill = !use_insert && !valid_reg[put_slot];

    always_comb
    begin
        touch_idx = upd.hit ? upd.idx : put_slot;
        touch_old = '0;
        age_all   = 1'b0;
        if (upd.hit)
        begin
            touch_old = rank_reg[upd.idx];
        end
        else if (use_insert)
        begin
            age_all = 1'b1;
        end
        else if (!plain_fill)
        begin
            touch_old = oldest;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        occ_next   = occ_reg;
        cap_next   = cap_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
        end

        if (cfg_we)
        begin
            cap_next = cfg_wdata;
            if (int'(occ_reg) > int'(cap_new))
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (valid_reg[i] && int'(rank_reg[i]) >= int'(cap_new))
                    begin
                        valid_next[i] = 1'b0;
                    end
                end
                occ_next = CNT_W'(cap_new);
            end
        end
        else if (upd.en)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (IDX_W'(i) == touch_idx)
                begin
                    rank_next[i] = '0;
                end
                else if (valid_reg[i] && (age_all || rank_reg[i] < touch_old))
                begin
                    rank_next[i] = rank_reg[i] + RANK_W'(1);
                end
            end
            if (!upd.hit && (use_insert || plain_fill))
            begin
                valid_next[put_slot] = 1'b1;
                occ_next             = occ_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg   <= '0;
            cap_reg   <= CAP_RESET;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
            cap_reg   <= cap_next;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    assign valid = valid_reg;

endmodule

FILE: hw/rtl/lru_key_value_cache.sv
// lru_key_value_cache: top level; request sequencer, key/value RAM and rank table.
// Uses lkv_pkg, lkv_kv_ram and lkv_rank_table.

// A fully associative key-value cache with least-recently-used replacement.
// Each request (tuser: 0 get, 1 put) carries a key and a value; each gives one
// response with found in tuser and the stored value in tdata (zero unless a
// get hit). Keys and values sit in one synchronous RAM that is scanned one entry
// per cycle. A request scans from entry 0 until the first hit or the last entry,
// then loads the response register once the output is free. One request is in
// work at a time, and the next is taken while the previous response still waits.
// Capacity may be written only while no request is in work; lowering it below
// occupancy drops the oldest entries at once.

module lru_key_value_cache
    import lkv_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration: capacity_in_use
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [CAP_W-1:0]               cfg_data,
    // request stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [KEY_BITS+VALUE_BITS-1:0] s_tdata,  // lookup_key, write_value
    input  logic                           s_tuser,  // mode
    // response stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [VALUE_BITS-1:0]          m_tdata,  // read_value
    output logic                           m_tuser   // found
);

    lkv_state_t state_reg, state_next;

    logic                         req_put_reg, req_put_next;
    logic signed [KEY_BITS-1:0]   req_key_reg, req_key_next;
    logic signed [VALUE_BITS-1:0] req_val_reg, req_val_next;
    logic [CNT_W-1:0]             scan_cnt_reg, scan_cnt_next;
    logic                         cmp_pend_reg, cmp_pend_next;
    logic [IDX_W-1:0]             cmp_idx_reg, cmp_idx_next;
    logic                         hit_reg, hit_next;
    logic [IDX_W-1:0]             hit_idx_reg, hit_idx_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         out_found_reg, out_found_next;
    logic signed [VALUE_BITS-1:0] out_value_reg, out_value_next;

    logic               in_xfer;
    logic               out_free;
    logic               cmp_hit;
    logic               cmp_last;
    logic               issue;
    logic [ENTRIES-1:0] valid;
    logic [IDX_W-1:0]   put_slot;
    logic [WORD_W-1:0]  rd_word;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    lkv_upd_t           upd;

    assign cfg_ready = 1'b1;
    assign in_xfer   = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;

    // compare stage works on the word read in the previous cycle
    assign cmp_hit  = cmp_pend_reg && valid[cmp_idx_reg]
                      && (rd_word[KEY_BITS-1:0] == req_key_reg);
    assign cmp_last = cmp_pend_reg && (cmp_idx_reg == IDX_W'(ENTRIES - 1));
    assign issue    = (state_reg == ST_SCAN) && !cmp_hit && !cmp_last
                      && (int'(scan_cnt_reg) < ENTRIES);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cmp_hit || cmp_last)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        s_tready       = 1'b0;
        req_put_next   = req_put_reg;
        req_key_next   = req_key_reg;
        req_val_next   = req_val_reg;
        scan_cnt_next  = scan_cnt_reg;
        cmp_pend_next  = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_found_next = out_found_reg;
        out_value_next = out_value_reg;
        upd            = '0;
        wr_en          = 1'b0;
        wr_addr        = hit_reg ? hit_idx_reg : put_slot;

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (in_xfer)
                begin
                    req_put_next  = (s_tuser == MODE_PUT);
                    req_key_next  = s_tdata[KEY_BITS-1:0];
                    req_val_next  = s_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS];
                    scan_cnt_next = '0;
                    hit_next      = 1'b0;
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                    cmp_pend_next = 1'b1;
                    cmp_idx_next  = scan_cnt_reg[IDX_W-1:0];
                end
                if (cmp_hit)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = cmp_idx_reg;
                end
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    upd.en         = hit_reg || req_put_reg;
                    upd.hit        = hit_reg;
                    upd.idx        = hit_idx_reg;
                    wr_en          = req_put_reg;
                    out_valid_next = 1'b1;
                    out_found_next = hit_reg;
                    out_value_next = (hit_reg && !req_put_reg)
                                     ? rd_word[WORD_W-1:KEY_BITS] : '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmp_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_pend_reg  <= cmp_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_put_reg   <= req_put_next;
        req_key_reg   <= req_key_next;
        req_val_reg   <= req_val_next;
        scan_cnt_reg  <= scan_cnt_next;
        cmp_idx_reg   <= cmp_idx_next;
        hit_reg       <= hit_next;
        hit_idx_reg   <= hit_idx_next;
        out_found_reg <= out_found_next;
        out_value_reg <= out_value_next;
    end

    lkv_kv_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (WORD_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({req_val_reg, req_key_reg}),
        .rd_en   (issue),
        .rd_addr (scan_cnt_reg[IDX_W-1:0]),
        .rd_data (rd_word)
    );

    lkv_rank_table u_rank (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_wdata (cfg_data),
        .upd       (upd),
        .valid     (valid),
        .put_slot  (put_slot)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_found_reg;

endmodule

FILE: hw/rtl/lkv_checker.sv
// lkv_checker: port-level assertions for lru_key_value_cache, bound to the top.
// Uses lkv_pkg.

module lkv_checker
    import lkv_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [VALUE_BITS-1:0] m_tdata,
    input logic                  m_tuser
);

    // a stalled response holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("response changed while stalled");

    // a miss carries zero data
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("miss response with nonzero data");

    // one request in work at a time
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while another is in work");

    // a response is not raised straight after its request; a scan comes first
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("response appeared right after request");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
